/* hdl/weight_rational_approx_lcm_unit_defines.svh */
// Assertion macros shared by the rational approximation unit.
`ifndef WEIGHT_RATIONAL_APPROX_LCM_UNIT_DEFINES_SVH
`define WEIGHT_RATIONAL_APPROX_LCM_UNIT_DEFINES_SVH
`ifndef ASSERT_OFF
`define WRAL_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define WRAL_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define WRAL_ASSERT(lbl, prop, msg)
`define WRAL_ASSERT_ALWAYS(lbl, prop, msg)
`endif
`endif

/* hdl/wral_pkg.sv */
// Types and constants of the rational approximation unit.
package wral_pkg;

  localparam int FRAC_BITS = 16;
  localparam int WORD_W    = 32;
  localparam int INT_W     = WORD_W - FRAC_BITS;
  localparam int P_W       = FRAC_BITS + 1;
  localparam int Q_W       = FRAC_BITS;
  localparam int DEN_W     = 10;
  localparam int NUM_W     = 26;
  localparam int H_W       = NUM_W + 1;
  localparam int MUL_A_W   = WORD_W;
  localparam int MUL_B_W   = P_W;
  localparam int PROD_W    = MUL_A_W + MUL_B_W;
  localparam int DSR_W     = Q_W;
  localparam int CNT_W     = 6;
  localparam int TDATA_W   = ((NUM_W + DEN_W + WORD_W + 7) / 8) * 8;
  localparam int PADDR_W   = 3;

  localparam logic [CNT_W-1:0] CNT_CF     = CNT_W'(P_W);
  localparam logic [CNT_W-1:0] CNT_NARROW = CNT_W'(DEN_W);
  localparam logic [CNT_W-1:0] CNT_WIDE   = CNT_W'(WORD_W);

  localparam logic [NUM_W-1:0] NUM_MAX = '1;

  // Register index taken from paddr[2].
  localparam logic REG_MAX_DEN = 1'b0;
  localparam logic [DEN_W-1:0] MAX_DEN_RESET = DEN_W'(100);

  typedef struct packed {
    logic              start;
    logic [WORD_W-1:0] dividend;
    logic [DSR_W-1:0]  divisor;
    logic [CNT_W-1:0]  count;
  } div_req_t;

  typedef struct packed {
    logic              busy;
    logic              done;
    logic [WORD_W-1:0] quot;
    logic [DSR_W-1:0]  rem;
  } div_rsp_t;

  typedef struct packed {
    logic [NUM_W-1:0]  numerator;
    logic [DEN_W-1:0]  denominator;
    logic [WORD_W-1:0] weight_base_out;
    logic              base_overflow;
  } wral_res_t;

endpackage

/* hdl/wral_div.sv */
// Shared restoring divider, one quotient bit per cycle over a left-aligned dividend.
module wral_div
  import wral_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  div_req_t req,
  output div_rsp_t rsp
);

  logic              busy;
  logic              done;
  logic [CNT_W-1:0]  cnt;
  logic [WORD_W-1:0] dvd;
  logic [WORD_W-1:0] quot;
  logic [DSR_W-1:0]  rem;
  logic [DSR_W-1:0]  dsr;
  logic [DSR_W:0]    rem_sh;
  logic [DSR_W+1:0]  diff;
  logic              ge;

  assign rem_sh = {rem, dvd[WORD_W-1]};
  assign diff   = {1'b0, rem_sh} - {2'b00, dsr};
  assign ge     = ~diff[DSR_W+1];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= req.count;
      end else if (busy) begin
        cnt <= cnt - CNT_W'(1);
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      dvd  <= req.dividend;
      dsr  <= req.divisor;
      rem  <= '0;
      quot <= '0;
    end else if (busy) begin
      dvd  <= {dvd[WORD_W-2:0], 1'b0};
      quot <= {quot[WORD_W-2:0], ge};
      // The shifted remainder stays below twice the divisor, so one subtract settles it.
      rem  <= ge ? diff[DSR_W-1:0] : rem_sh[DSR_W-1:0];
    end
  end

  assign rsp.busy = busy;
  assign rsp.done = done;
  assign rsp.quot = quot;
  assign rsp.rem  = rem;

endmodule

/* hdl/wral_core.sv */
// Sequencer for the continued-fraction expansion and the LCM update of the weight base.
`include "weight_rational_approx_lcm_unit_defines.svh"
module wral_core
  import wral_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [WORD_W-1:0] weight,
  input  logic [DEN_W-1:0]  lim,
  output logic              res_valid,
  input  logic              res_ready,
  output wral_res_t         res
);

  localparam logic [4:0] S_IDLE    = 5'd0;
  localparam logic [4:0] S_CF_DIV  = 5'd1;
  localparam logic [4:0] S_CF_WAIT = 5'd2;
  localparam logic [4:0] S_CF_MULK = 5'd3;
  localparam logic [4:0] S_CF_CHK  = 5'd4;
  localparam logic [4:0] S_CF_MULH = 5'd5;
  localparam logic [4:0] S_CF_UPD  = 5'd6;
  localparam logic [4:0] S_BASE    = 5'd7;
  localparam logic [4:0] S_G_WIDE  = 5'd8;
  localparam logic [4:0] S_G_WWAIT = 5'd9;
  localparam logic [4:0] S_G_TEST  = 5'd10;
  localparam logic [4:0] S_G_NWAIT = 5'd11;
  localparam logic [4:0] S_L_DIV   = 5'd12;
  localparam logic [4:0] S_L_WAIT  = 5'd13;
  localparam logic [4:0] S_L_MUL   = 5'd14;
  localparam logic [4:0] S_L_CHK   = 5'd15;
  localparam logic [4:0] S_DONE    = 5'd16;

  logic [4:0]         state;
  logic [P_W-1:0]     p;
  logic [Q_W-1:0]     q;
  logic [H_W-1:0]     h1;
  logic [H_W-1:0]     h0;
  logic [DEN_W-1:0]   k1;
  logic [DEN_W-1:0]   k0;
  logic [DEN_W-1:0]   kt;
  logic [DEN_W-1:0]   ga;
  logic [DEN_W-1:0]   gb;
  logic [WORD_W-1:0]  weight_base;
  logic               ovf;
  logic [PROD_W-1:0]  prod;
  logic [MUL_A_W-1:0] mul_a;
  logic [MUL_B_W-1:0] mul_b;
  logic [PROD_W-1:0]  mul_out;
  logic [PROD_W-1:0]  kt_full;
  logic               lcm_wide;
  logic               div_waiting;
  logic               ovf_hold;
  div_req_t           div_req;
  div_rsp_t           div_rsp;

  wral_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  always_comb begin
    div_req.start    = 1'b0;
    div_req.dividend = {p, {(WORD_W - P_W){1'b0}}};
    div_req.divisor  = q;
    div_req.count    = CNT_CF;
    unique case (state)
      S_CF_DIV: begin
        div_req.start = 1'b1;
      end
      S_G_WIDE: begin
        div_req.start    = 1'b1;
        div_req.dividend = weight_base;
        div_req.divisor  = {{(DSR_W - DEN_W){1'b0}}, k1};
        div_req.count    = CNT_WIDE;
      end
      S_G_TEST: begin
        div_req.start    = (gb != '0);
        div_req.dividend = {ga, {(WORD_W - DEN_W){1'b0}}};
        div_req.divisor  = {{(DSR_W - DEN_W){1'b0}}, gb};
        div_req.count    = CNT_NARROW;
      end
      S_L_DIV: begin
        div_req.start    = 1'b1;
        div_req.dividend = weight_base;
        div_req.divisor  = {{(DSR_W - DEN_W){1'b0}}, ga};
        div_req.count    = CNT_WIDE;
      end
      default: begin
      end
    endcase
  end

  // One multiplier serves the two convergent updates and the LCM product.
  always_comb begin
    unique case (state)
      S_CF_MULH: begin
        mul_a = {{(MUL_A_W - H_W){1'b0}}, h1};
        mul_b = div_rsp.quot[MUL_B_W-1:0];
      end
      S_L_MUL: begin
        mul_a = div_rsp.quot;
        mul_b = {{(MUL_B_W - DEN_W){1'b0}}, k1};
      end
      default: begin
        mul_a = {{(MUL_A_W - DEN_W){1'b0}}, k1};
        mul_b = div_rsp.quot[MUL_B_W-1:0];
      end
    endcase
  end

  assign mul_out  = mul_a * mul_b;
  assign kt_full  = prod + {{(PROD_W - DEN_W){1'b0}}, k0};
  assign lcm_wide = (prod[PROD_W-1:WORD_W] != '0);

  always_ff @(posedge clk) begin
    if (state == S_CF_MULK || state == S_CF_MULH || state == S_L_MUL) begin
      prod <= mul_out;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      weight_base <= WORD_W'(1);
      ovf         <= 1'b0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            // The first term always fits: integer part over one.
            h1  <= {{(H_W - INT_W){1'b0}}, weight[WORD_W-1:FRAC_BITS]};
            h0  <= H_W'(1);
            k1  <= DEN_W'(1);
            k0  <= '0;
            p   <= P_W'(1) << FRAC_BITS;
            q   <= weight[Q_W-1:0];
            ovf <= 1'b0;
            state <= (weight[Q_W-1:0] == '0) ? S_BASE : S_CF_DIV;
          end
        end
        S_CF_DIV: begin
          state <= S_CF_WAIT;
        end
        S_CF_WAIT: begin
          if (div_rsp.done) begin
            state <= S_CF_MULK;
          end
        end
        S_CF_MULK: begin
          state <= S_CF_CHK;
        end
        S_CF_CHK: begin
          kt <= kt_full[DEN_W-1:0];
          state <= (kt_full > {{(PROD_W - DEN_W){1'b0}}, lim}) ? S_BASE : S_CF_MULH;
        end
        S_CF_MULH: begin
          state <= S_CF_UPD;
        end
        S_CF_UPD: begin
          h0 <= h1;
          h1 <= prod[H_W-1:0] + h0;
          k0 <= k1;
          k1 <= kt;
          p  <= {1'b0, q};
          q  <= div_rsp.rem;
          state <= (div_rsp.rem == '0) ? S_BASE : S_CF_DIV;
        end
        S_BASE: begin
          state <= ({{(WORD_W - DEN_W){1'b0}}, k1} == weight_base) ? S_DONE : S_G_WIDE;
        end
        S_G_WIDE: begin
          state <= S_G_WWAIT;
        end
        S_G_WWAIT: begin
          if (div_rsp.done) begin
            ga <= k1;
            gb <= div_rsp.rem[DEN_W-1:0];
            state <= S_G_TEST;
          end
        end
        S_G_TEST: begin
          state <= (gb == '0) ? S_L_DIV : S_G_NWAIT;
        end
        S_G_NWAIT: begin
          if (div_rsp.done) begin
            ga <= gb;
            gb <= div_rsp.rem[DEN_W-1:0];
            state <= S_G_TEST;
          end
        end
        S_L_DIV: begin
          state <= S_L_WAIT;
        end
        S_L_WAIT: begin
          if (div_rsp.done) begin
            state <= S_L_MUL;
          end
        end
        S_L_MUL: begin
          state <= S_L_CHK;
        end
        S_L_CHK: begin
          if (lcm_wide) begin
            ovf <= 1'b1;
          end else begin
            weight_base <= prod[WORD_W-1:0];
          end
          state <= S_DONE;
        end
        S_DONE: begin
          if (res_ready) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  assign in_ready  = (state == S_IDLE);
  assign res_valid = (state == S_DONE);

  assign res.numerator       = (h1 > {1'b0, NUM_MAX}) ? NUM_MAX : h1[NUM_W-1:0];
  assign res.denominator     = k1;
  assign res.weight_base_out = weight_base;
  assign res.base_overflow   = ovf;

  assign div_waiting = (state == S_CF_WAIT) || (state == S_G_WWAIT) ||
                       (state == S_G_NWAIT) || (state == S_L_WAIT);
  assign ovf_hold    = (state == S_L_CHK) && lcm_wide;

  `WRAL_ASSERT(a_idle_div_quiet, in_ready |-> !div_rsp.busy, "divider busy while idle")
  `WRAL_ASSERT(a_den_in_range, res_valid |-> (k1 != '0 && k1 <= lim), "denominator out of range")
  `WRAL_ASSERT(a_base_nonzero, weight_base != '0, "weight base became zero")
  `WRAL_ASSERT(a_ovf_holds_base, ovf_hold |=> $stable(weight_base), "base changed on overflow")
  `WRAL_ASSERT(a_done_expected, div_rsp.done |-> div_waiting, "divider result with no waiter")

endmodule

/* hdl/weight_rational_approx_lcm_unit.sv */
// Top level: configuration port, sequencer and output register of the rational approximation unit.
//
//   Channel   Direction  Handshake                  Payload
//   s_axis    in         s_tvalid / s_tready        s_tdata[31:0] weight_q16
//   m_axis    out        m_tvalid / m_tready        m_tdata numerator, denominator, base; m_tuser
//   apb       in         psel, penable, pwrite      paddr[2] register, pwdata[9:0] max_denominator
//
// Per item the sequencer takes the integer part, then per further continued-fraction term one
// divider pass and the convergent multiplies, and for a new base a wide GCD division, narrow GCD
// steps, the LCM division and the product, all on the shared divider and multiplier.
// Reset (rst, synchronous) sets max_denominator to 100 and the weight base to 1.
// s_tready is high only while the sequencer is idle; a finished result waits in the output
// register, and a new item is taken while it waits.
module weight_rational_approx_lcm_unit
  import wral_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               s_tvalid,
  output logic               s_tready,
  input  logic [WORD_W-1:0]  s_tdata,   // [31:0] weight_q16
  output logic               m_tvalid,
  input  logic               m_tready,
  output logic [TDATA_W-1:0] m_tdata,   // [25:0] numerator, [35:26] denominator,
                                        // [67:36] weight_base_out, [71:68] zero
  output logic               m_tuser,   // [0] base_overflow
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  logic [DEN_W-1:0] max_denominator;
  logic [DEN_W-1:0] lim;
  logic             res_valid;
  logic             res_ready;
  wral_res_t        res;

  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_denominator <= MAX_DEN_RESET;
    end else if (psel && penable && pwrite && pready && paddr[2] == REG_MAX_DEN) begin
      max_denominator <= pwdata[DEN_W-1:0];
    end
  end

  assign prdata = (paddr[2] == REG_MAX_DEN) ? {{(32 - DEN_W){1'b0}}, max_denominator} : '0;

  // A zero limit acts as one.
  assign lim = (max_denominator == '0) ? DEN_W'(1) : max_denominator;

  wral_core u_core (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .weight    (s_tdata),
    .lim       (lim),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res)
  );

  assign res_ready = !m_tvalid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (res_ready) begin
      m_tvalid <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      m_tdata <= {{(TDATA_W - NUM_W - DEN_W - WORD_W){1'b0}},
                  res.weight_base_out, res.denominator, res.numerator};
      m_tuser <= res.base_overflow;
    end
  end

endmodule

/* verif/weight_rational_approx_lcm_unit_tb.sv */
// Self-checking testbench of the rational approximation and weight base unit.
`timescale 1ns / 100ps

module weight_rational_approx_lcm_unit_tb
  import wral_pkg::*;
();

  localparam logic [PADDR_W-1:0] MAX_DEN_ADDR = {REG_MAX_DEN, 2'b00};
  localparam longint unsigned WORD_LIMIT = 64'hFFFF_FFFF;
  localparam int PHASE_ITEMS = 160;
  localparam int NUM_PHASES  = 8;

  // Expected approximations in order of acceptance, with the unit's own state mirrored.
  class rational_scoreboard;
    wral_res_t        expected_ratios[$];
    logic [DEN_W-1:0] max_den;
    longint unsigned  weight_base;
    int               errors;

    function new();
      max_den     = MAX_DEN_RESET;
      weight_base = 1;
      errors      = 0;
    endfunction

    function void set_max_den(logic [31:0] value);
      max_den = value[DEN_W-1:0];
    endfunction

    function int pending();
      return expected_ratios.size();
    endfunction

    // Continued-fraction expansion by exact Euclid steps, then the LCM update of the base.
    function wral_res_t approximate_weight(logic [WORD_W-1:0] weight);
      wral_res_t       res;
      longint unsigned lim, p, q, h1, h0, k1, k0, ai, r, t, g, a, b, l;
      logic            ovf;
      lim = (max_den == 0) ? 1 : max_den;
      p = weight;
      q = 64'd1 << FRAC_BITS;
      h1 = 1;
      h0 = 0;
      k1 = 0;
      k0 = 1;
      ovf = 1'b0;
      while (1'b1) begin
        ai = p / q;
        r  = p % q;
        if (k1 * ai + k0 > lim) break;
        t  = h1 * ai + h0;
        h0 = h1;
        h1 = t;
        t  = k1 * ai + k0;
        k0 = k1;
        k1 = t;
        if (r == 0) break;
        p = q;
        q = r;
      end
      if (k1 != weight_base) begin
        a = weight_base;
        b = k1;
        while (b != 0) begin
          t = a % b;
          a = b;
          b = t;
        end
        g = a;
        l = (weight_base / g) * k1;
        if (l > WORD_LIMIT) ovf = 1'b1;
        else weight_base = l;
      end
      res.numerator       = (h1 > longint'(NUM_MAX)) ? NUM_MAX : h1[NUM_W-1:0];
      res.denominator     = k1[DEN_W-1:0];
      res.weight_base_out = weight_base[WORD_W-1:0];
      res.base_overflow   = ovf;
      return res;
    endfunction

    function void note_weight(logic [WORD_W-1:0] weight);
      expected_ratios.push_back(approximate_weight(weight));
    endfunction

    function void check_result(logic [TDATA_W-1:0] tdata, logic tuser);
      wral_res_t exp_res, got;
      got.numerator       = tdata[NUM_W-1:0];
      got.denominator     = tdata[NUM_W +: DEN_W];
      got.weight_base_out = tdata[NUM_W+DEN_W +: WORD_W];
      got.base_overflow   = tuser;
      if (expected_ratios.size() == 0) begin
        $display("%0t: unexpected result, actual num=%0d den=%0d base=%0d ovf=%0b", $time,
                 got.numerator, got.denominator, got.weight_base_out, got.base_overflow);
        errors++;
        return;
      end
      exp_res = expected_ratios.pop_front();
      if (got.numerator !== exp_res.numerator) begin
        $display("%0t: numerator expected %0d actual %0d", $time,
                 exp_res.numerator, got.numerator);
        errors++;
      end
      if (got.denominator !== exp_res.denominator) begin
        $display("%0t: denominator expected %0d actual %0d", $time,
                 exp_res.denominator, got.denominator);
        errors++;
      end
      if (got.weight_base_out !== exp_res.weight_base_out) begin
        $display("%0t: weight base expected %0d actual %0d", $time,
                 exp_res.weight_base_out, got.weight_base_out);
        errors++;
      end
      if (got.base_overflow !== exp_res.base_overflow) begin
        $display("%0t: base overflow expected %0b actual %0b", $time,
                 exp_res.base_overflow, got.base_overflow);
        errors++;
      end
      if (tdata[TDATA_W-1:NUM_W+DEN_W+WORD_W] !== '0) begin
        $display("%0t: tdata padding expected 0 actual %0h", $time,
                 tdata[TDATA_W-1:NUM_W+DEN_W+WORD_W]);
        errors++;
      end
    endfunction
  endclass

  logic               clk;
  logic               rst;
  logic               s_tvalid;
  logic               s_tready;
  logic [WORD_W-1:0]  s_tdata;
  logic               m_tvalid;
  logic               m_tready;
  logic [TDATA_W-1:0] m_tdata;
  logic               m_tuser;
  logic               psel;
  logic               penable;
  logic               pwrite;
  logic [PADDR_W-1:0] paddr;
  logic [31:0]        pwdata;
  logic [31:0]        prdata;
  logic               pready;

  rational_scoreboard ratios = new();
  bit send_gaps;
  bit stall_enable;
  int gap_pct;

  weight_rational_approx_lcm_unit dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  initial begin
    #30_000_000;
    $display("TB_ERROR");
    $finish;
  end

  // Result side: ready drops in random bursts while stalls are enabled.
  initial begin
    m_tready = 1'b0;
    forever begin
      if (stall_enable && $urandom_range(0, 3) == 0) begin
        m_tready <= 1'b0;
        repeat ($urandom_range(1, 9)) @(posedge clk);
      end
      m_tready <= 1'b1;
      repeat ($urandom_range(1, 20)) @(posedge clk);
    end
  end

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) ratios.check_result(m_tdata, m_tuser);
  end

  task automatic write_max_den(input logic [31:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= MAX_DEN_ADDR;
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    ratios.set_max_den(value);
  endtask

  task automatic send_weight(input logic [WORD_W-1:0] weight);
    s_tvalid <= 1'b1;
    s_tdata  <= weight;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    ratios.note_weight(weight);
    if (send_gaps && $urandom_range(0, 99) < gap_pct) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 9)) @(posedge clk);
    end
  endtask

  task automatic drain_results();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (ratios.pending() != 0) @(posedge clk);
  endtask

  // Mix of weights: arbitrary words, near-rational fractions, integers, tiny and huge values.
  function automatic logic [WORD_W-1:0] random_weight();
    logic [WORD_W-1:0] w;
    int unsigned       den, num, ip;
    case ($urandom_range(0, 7))
      0, 1: w = $urandom;
      2: begin
        den = $urandom_range(1, 1023);
        num = $urandom_range(0, den - 1);
        ip  = $urandom_range(0, 255);
        w   = (ip << FRAC_BITS) | ((num << FRAC_BITS) / den);
      end
      3: w = $urandom_range(0, 65535) << FRAC_BITS;
      4: w = $urandom_range(0, 255);
      5: w = $urandom | 32'hFF00_0000;
      6: w = $urandom_range(0, 65535);
      default: w = $urandom & ~((32'd1 << $urandom_range(0, 16)) - 1);
    endcase
    return w;
  endfunction

  initial begin
    logic [WORD_W-1:0] directed_weights[$];
    logic [31:0]       cfg;
    rst          = 1'b1;
    s_tvalid     = 1'b0;
    s_tdata      = '0;
    psel         = 1'b0;
    penable      = 1'b0;
    pwrite       = 1'b0;
    paddr        = '0;
    pwdata       = '0;
    send_gaps    = 1'b1;
    stall_enable = 1'b1;
    gap_pct      = 30;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Zero, extremes, exact integers and fractions, and well-known irrationals.
    directed_weights = {32'h0000_0000, 32'h0000_0001, 32'hFFFF_FFFF, 32'h0001_0000,
                        32'h0000_8000, 32'h0000_5555, 32'h0000_AAAB, 32'h0003_243F,
                        32'h0002_B7E1, 32'h0001_6A0A, 32'h0000_FFFF, 32'hFFFF_0000,
                        32'h8000_0000, 32'h7FFF_FFFF, 32'h0001_8000, 32'h0000_199A,
                        32'h000A_0000, 32'h0000_4000, 32'h0000_0000, 32'h0001_5555};
    foreach (directed_weights[i]) send_weight(directed_weights[i]);
    drain_results();

    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      case (ph)
        0: cfg = 32'd1;
        1: cfg = 32'd1023;
        2: cfg = 32'hFFFF_FC00;  // upper bits set, the register itself reads as zero
        3: cfg = 32'd2;
        NUM_PHASES - 1: cfg = 32'd1023;
        default: cfg = $urandom_range(1, 1023) | ($urandom & 32'hFFFF_FC00);
      endcase
      write_max_den(cfg);
      gap_pct = $urandom_range(5, 60);
      if (ph == NUM_PHASES - 1) begin
        send_gaps    = 1'b0;
        stall_enable = 1'b0;
      end
      for (int n = 0; n < PHASE_ITEMS; n++) send_weight(random_weight());
      // The sender holds off here until every expected result has come back.
      drain_results();
    end

    repeat (50) @(posedge clk);
    if (ratios.errors == 0 && ratios.pending() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
